### hdl/gdm_pkg.sv
// shared types, constants and status codes of the gravitational dilation measure
package gdm_pkg;

    localparam int BODY_COUNT = 16;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SAT   = 2'd1;
    localparam logic [1:0] STATUS_UNDEF = 2'd2;

    localparam logic [1:0] REG_OBS_X = 2'd0;
    localparam logic [1:0] REG_OBS_Y = 2'd1;
    localparam logic [1:0] REG_OBS_Z = 2'd2;
    localparam logic [1:0] REG_MASS  = 2'd3;

    localparam logic [31:0] MASS_RESET = 32'd65536;

    typedef struct packed {
        logic        [3:0]  body_index;
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
        logic signed [31:0] body_z;
        logic signed [63:0] body_proper_time;
        logic signed [63:0] coordinate_time;
    } body_word_t;

    typedef struct packed {
        logic        [3:0]  index_out;
        logic        [31:0] distance;
        logic signed [31:0] dilation;
        logic signed [63:0] tau_out;
        logic signed [63:0] observer_time;
        logic        [1:0]  status;
    } result_word_t;

    typedef struct packed {
        logic [31:0] obs_x;
        logic [31:0] obs_y;
        logic [31:0] obs_z;
        logic [31:0] mass;
    } gdm_cfg_t;

    typedef struct packed {
        logic [3:0]  index;
        logic [63:0] tau;
        logic [63:0] tc;
    } gdm_tag_t;

    // one square root lane: radicand shifts out two bits a step
    typedef struct packed {
        logic [63:0] num;
        logic [32:0] rem;
        logic [31:0] root;
    } gdm_sqrt_lane_t;

    // lane 0 distance, lane 1 observer radius, lane 2 body radius
    typedef struct packed {
        gdm_tag_t                 tag;
        logic                     dsat;
        gdm_sqrt_lane_t [2:0]     lane;
    } gdm_sqrt_t;

    // one restoring division lane: dividend bits shift in one a step
    typedef struct packed {
        logic [33:0] rem;
        logic [33:0] dvsr;
        logic [31:0] num;
        logic [31:0] quot;
    } gdm_div_lane_t;

    typedef struct packed {
        gdm_tag_t             tag;
        logic [31:0]          distance;
        logic                 dsat;
        logic                 obs_zero;
        logic                 body_zero;
        logic                 undef_obs;
        logic                 ao_neg;
        logic                 ab_neg;
        logic                 t_neg;
        logic                 qovf;
        logic [63:0]          tm;
        logic [63:0]          p_lo;
        logic [63:0]          p_hi;
        gdm_div_lane_t [1:0]  lane;
    } gdm_div_t;

endpackage

### hdl/gdm_front.sv
// front end: coordinate magnitudes, squares and sums of squares over three stages
module gdm_front
    import gdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  gdm_cfg_t   cfg,
    input  logic       up_valid,
    output logic       up_ready,
    input  body_word_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output gdm_sqrt_t  dn_data
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        r1, r2, r3;
    gdm_tag_t    tag1_reg, tag2_reg;
    logic [32:0] dm_reg [3];
    logic [31:0] bm_reg [3];
    logic [31:0] om_reg [3];
    logic [63:0] dsq_reg [3];
    logic [63:0] bsq_reg [3];
    logic [63:0] osq_reg [3];
    gdm_sqrt_t   s3_reg;

    logic [31:0] bc [3];
    logic [31:0] oc [3];
    logic [32:0] d  [3];
    logic [32:0] dm_next [3];
    logic [31:0] bm_next [3];
    logic [31:0] om_next [3];
    logic [65:0] dp [3];
    logic [65:0] dsum;
    logic        in_range;
    gdm_sqrt_t   s3_next;

    // stall chain, a stage takes a word when it is empty or moves on
    assign r3       = !v3_reg || dn_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign up_ready = r1;
    assign in_range = {5'b0, up_data.body_index} < 9'(BODY_COUNT);

    // magnitudes of coordinates and of differences
    always_comb
    begin
        bc[0] = up_data.body_x;
        bc[1] = up_data.body_y;
        bc[2] = up_data.body_z;
        oc[0] = cfg.obs_x;
        oc[1] = cfg.obs_y;
        oc[2] = cfg.obs_z;
        for (int i = 0; i < 3; i++)
        begin
            d[i]       = {bc[i][31], bc[i]} - {oc[i][31], oc[i]};
            dm_next[i] = d[i][32] ? (~d[i] + 33'd1) : d[i];
            bm_next[i] = bc[i][31] ? (~bc[i] + 32'd1) : bc[i];
            om_next[i] = oc[i][31] ? (~oc[i] + 32'd1) : oc[i];
        end
    end

    // sums of squares, the distance sum may carry past 64 bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp[i] = {2'b0, dsq_reg[i]};
        end
        dsum    = dp[0] + dp[1] + dp[2];
        s3_next = '0;
        s3_next.tag          = tag2_reg;
        s3_next.dsat         = |dsum[65:64];
        s3_next.lane[0].num  = dsum[63:0];
        s3_next.lane[1].num  = osq_reg[0] + osq_reg[1] + osq_reg[2];
        s3_next.lane[2].num  = bsq_reg[0] + bsq_reg[1] + bsq_reg[2];
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= up_valid && in_range;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (r1 && up_valid)
        begin
            tag1_reg.index <= up_data.body_index;
            tag1_reg.tau   <= up_data.body_proper_time;
            tag1_reg.tc    <= up_data.coordinate_time;
            for (int i = 0; i < 3; i++)
            begin
                dm_reg[i] <= dm_next[i];
                bm_reg[i] <= bm_next[i];
                om_reg[i] <= om_next[i];
            end
        end
        if (r2 && v1_reg)
        begin
            tag2_reg <= tag1_reg;
            for (int i = 0; i < 3; i++)
            begin
                dsq_reg[i] <= 64'({33'b0, dm_reg[i]} * {33'b0, dm_reg[i]});
                bsq_reg[i] <= {32'b0, bm_reg[i]} * {32'b0, bm_reg[i]};
                osq_reg[i] <= {32'b0, om_reg[i]} * {32'b0, om_reg[i]};
            end
        end
        if (r3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign dn_valid = v3_reg;
    assign dn_data  = s3_reg;

endmodule

### hdl/gdm_sqrt_cell.sv
// square root cell: one result bit for each of three lanes
module gdm_sqrt_cell
    import gdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  gdm_sqrt_t up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output gdm_sqrt_t dn_data
);

    logic      valid_reg;
    gdm_sqrt_t data_reg;
    gdm_sqrt_t data_next;
    logic [34:0] t     [3];
    logic [34:0] trial [3];

    assign up_ready = !valid_reg || dn_ready;

    // bring in two radicand bits, try root*4+1
    always_comb
    begin
        data_next = up_data;
        for (int l = 0; l < 3; l++)
        begin
            t[l]     = {up_data.lane[l].rem, up_data.lane[l].num[63:62]};
            trial[l] = {1'b0, up_data.lane[l].root, 2'b01};
            data_next.lane[l].num = {up_data.lane[l].num[61:0], 2'b00};
            if (t[l] >= trial[l])
            begin
                data_next.lane[l].rem  = 33'(t[l] - trial[l]);
                data_next.lane[l].root = {up_data.lane[l].root[30:0], 1'b1};
            end
            else
            begin
                data_next.lane[l].rem  = t[l][32:0];
                data_next.lane[l].root = {up_data.lane[l].root[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### hdl/gdm_lapse_setup.sv
// lapse setup: radii to lapse dividends and divisors, time magnitude
module gdm_lapse_setup
    import gdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] mass,
    input  logic        up_valid,
    output logic        up_ready,
    input  gdm_sqrt_t   up_data,
    output logic        dn_valid,
    input  logic        dn_ready,
    output gdm_div_t    dn_data
);

    logic        valid_reg;
    gdm_div_t    data_reg;
    gdm_div_t    data_next;
    logic [31:0] r    [2];
    logic [32:0] two_r[2];
    logic [32:0] diff [2];
    logic [33:0] den  [2];
    logic        neg  [2];

    assign up_ready = !valid_reg || dn_ready;

    // lapse magnitude is |2r-m| * 2^31 / (2r+m), high dividend half preloaded
    always_comb
    begin
        data_next = '0;
        r[0] = up_data.lane[1].root;
        r[1] = up_data.lane[2].root;
        for (int l = 0; l < 2; l++)
        begin
            two_r[l] = {r[l], 1'b0};
            den[l]   = {1'b0, two_r[l]} + {2'b0, mass};
            neg[l]   = two_r[l] < {1'b0, mass};
            diff[l]  = neg[l] ? ({1'b0, mass} - two_r[l]) : (two_r[l] - {1'b0, mass});
            data_next.lane[l].rem  = {2'b0, diff[l][32:1]};
            data_next.lane[l].dvsr = den[l];
            data_next.lane[l].num  = {diff[l][0], 31'b0};
            data_next.lane[l].quot = '0;
        end
        data_next.tag       = up_data.tag;
        data_next.dsat      = up_data.dsat;
        data_next.distance  = up_data.dsat ? 32'hFFFF_FFFF : up_data.lane[0].root;
        data_next.obs_zero  = r[0] == 32'd0;
        data_next.body_zero = r[1] == 32'd0;
        data_next.ao_neg    = neg[0];
        data_next.ab_neg    = neg[1];
        data_next.t_neg     = up_data.tag.tc[63];
        data_next.tm        = up_data.tag.tc[63] ? (~up_data.tag.tc + 64'd1) : up_data.tag.tc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### hdl/gdm_div_cell.sv
// division cell: one restoring quotient bit for each of two lanes
module gdm_div_cell
    import gdm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  gdm_div_t up_data,
    output logic     dn_valid,
    input  logic     dn_ready,
    output gdm_div_t dn_data
);

    logic        valid_reg;
    gdm_div_t    data_reg;
    gdm_div_t    data_next;
    logic [34:0] t [2];

    assign up_ready = !valid_reg || dn_ready;

    // shift in the next dividend bit, subtract the divisor if it fits
    always_comb
    begin
        data_next = up_data;
        for (int l = 0; l < 2; l++)
        begin
            t[l] = {up_data.lane[l].rem, up_data.lane[l].num[31]};
            data_next.lane[l].num = {up_data.lane[l].num[30:0], 1'b0};
            if (t[l] >= {1'b0, up_data.lane[l].dvsr})
            begin
                data_next.lane[l].rem  = 34'(t[l] - {1'b0, up_data.lane[l].dvsr});
                data_next.lane[l].quot = {up_data.lane[l].quot[30:0], 1'b1};
            end
            else
            begin
                data_next.lane[l].rem  = t[l][33:0];
                data_next.lane[l].quot = {up_data.lane[l].quot[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### hdl/gdm_ratio_setup.sv
// ratio setup: lapse ratio dividend, overflow check and time partial products
module gdm_ratio_setup
    import gdm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  gdm_div_t up_data,
    output logic     dn_valid,
    input  logic     dn_ready,
    output gdm_div_t dn_data
);

    logic        valid_reg;
    gdm_div_t    data_reg;
    gdm_div_t    data_next;
    logic [31:0] ao;
    logic [31:0] ab;

    assign up_ready = !valid_reg || dn_ready;
    assign ao       = up_data.lane[0].quot;
    assign ab       = up_data.lane[1].quot;

    // quotient ab*2^16/ao overflows 32 bits when ab>>16 reaches ao
    always_comb
    begin
        data_next = up_data;
        data_next.undef_obs    = up_data.obs_zero || (ao == 32'd0);
        data_next.qovf         = {16'b0, ab[31:16]} >= ao;
        data_next.lane[0].rem  = {18'b0, ab[31:16]};
        data_next.lane[0].dvsr = {2'b0, ao};
        data_next.lane[0].num  = {ab[15:0], 16'b0};
        data_next.lane[0].quot = '0;
        data_next.lane[1]      = '0;
        data_next.p_lo         = {32'b0, up_data.tm[31:0]} * {32'b0, ao};
        data_next.p_hi         = {32'b0, up_data.tm[63:32]} * {32'b0, ao};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### hdl/gdm_finish.sv
// finish stage: saturation, signs, status and the output register
module gdm_finish
    import gdm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  gdm_div_t     up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output result_word_t dn_data
);

    logic         valid_reg;
    result_word_t data_reg;
    result_word_t data_next;
    logic [64:0]  r65;
    logic [63:0]  r;
    logic [63:0]  limit;
    logic [63:0]  rs;
    logic [63:0]  otime;
    logic         oneg;
    logic         osat;
    logic [31:0]  q;
    logic [31:0]  lim32;
    logic [31:0]  qs;
    logic [31:0]  dil;
    logic         dneg;
    logic         qsat;

    assign up_ready = !valid_reg || dn_ready;

    // observer time from partial products, saturated to 64 bits signed
    always_comb
    begin
        r65   = {up_data.p_hi, 1'b0} + {32'b0, up_data.p_lo[63:31]};
        r     = r65[63:0];
        oneg  = up_data.t_neg ^ up_data.ao_neg;
        limit = oneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        osat  = (|up_data.p_hi[63:62]) || (r > limit);
        rs    = osat ? limit : r;
        otime = oneg ? (~rs + 64'd1) : rs;
    end

    // lapse ratio, saturated to 32 bits signed
    always_comb
    begin
        q     = up_data.lane[0].quot;
        dneg  = (up_data.ab_neg != up_data.ao_neg) && (up_data.qovf || (q != 32'd0));
        lim32 = dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        qsat  = up_data.qovf || (q > lim32);
        qs    = qsat ? lim32 : q;
        dil   = dneg ? (~qs + 32'd1) : qs;
    end

    // undefined cases override saturation
    always_comb
    begin
        data_next.index_out = up_data.tag.index;
        data_next.distance  = up_data.distance;
        data_next.tau_out   = up_data.tag.tau;
        priority if (up_data.undef_obs)
        begin
            data_next.dilation      = '0;
            data_next.observer_time = '0;
            data_next.status        = STATUS_UNDEF;
        end
        else if (up_data.body_zero)
        begin
            data_next.dilation      = '0;
            data_next.observer_time = otime;
            data_next.status        = STATUS_UNDEF;
        end
        else
        begin
            data_next.dilation      = dil;
            data_next.observer_time = otime;
            data_next.status        = (up_data.dsat || osat || qsat) ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### hdl/gravitational_dilation_measure.sv
// top level of the gravitational dilation measure: register port and cell rows
// One body word is taken every clock when the output side keeps up: three front
// stages form the squares, a row of 32 square root cells yields distance and
// both radii a bit per cell, a row of 32 division cells yields both lapses, a
// second row of 32 division cells yields the lapse ratio, and three single
// stages set up, combine and register the result. Every stage holds its word
// only while the stage after it is full, so empty slots close up under
// back-pressure. Words with a body index of BODY_COUNT or more are dropped and
// give no result.
module gravitational_dilation_measure
    import gdm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         body_valid,
    output logic         body_ready,
    input  body_word_t   body_word,
    output logic         result_valid,
    input  logic         result_ready,
    output result_word_t result_word
);

    localparam int STEPS = 32;

    logic [31:0] obs_x_reg, obs_y_reg, obs_z_reg, mass_reg;
    gdm_cfg_t    cfg;

    logic      sq_valid [STEPS+1];
    logic      sq_ready [STEPS+1];
    gdm_sqrt_t sq_data  [STEPS+1];
    logic      lp_valid [STEPS+1];
    logic      lp_ready [STEPS+1];
    gdm_div_t  lp_data  [STEPS+1];
    logic      rt_valid [STEPS+1];
    logic      rt_ready [STEPS+1];
    gdm_div_t  rt_data  [STEPS+1];

    // register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obs_x_reg <= '0;
            obs_y_reg <= '0;
            obs_z_reg <= '0;
            mass_reg  <= MASS_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                REG_OBS_X: obs_x_reg <= pwdata;
                REG_OBS_Y: obs_y_reg <= pwdata;
                REG_OBS_Z: obs_z_reg <= pwdata;
                REG_MASS:  mass_reg  <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_OBS_X: prdata = obs_x_reg;
            REG_OBS_Y: prdata = obs_y_reg;
            REG_OBS_Z: prdata = obs_z_reg;
            REG_MASS:  prdata = mass_reg;
        endcase
    end

    assign cfg.obs_x = obs_x_reg;
    assign cfg.obs_y = obs_y_reg;
    assign cfg.obs_z = obs_z_reg;
    assign cfg.mass  = mass_reg;

    // squares and sums
    gdm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (body_valid),
        .up_ready (body_ready),
        .up_data  (body_word),
        .dn_valid (sq_valid[0]),
        .dn_ready (sq_ready[0]),
        .dn_data  (sq_data[0])
    );

    // square root row
    for (genvar i = 0; i < STEPS; i++)
    begin : g_sqrt
        gdm_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (sq_valid[i]),
            .up_ready (sq_ready[i]),
            .up_data  (sq_data[i]),
            .dn_valid (sq_valid[i+1]),
            .dn_ready (sq_ready[i+1]),
            .dn_data  (sq_data[i+1])
        );
    end

    gdm_lapse_setup u_lapse_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .mass     (mass_reg),
        .up_valid (sq_valid[STEPS]),
        .up_ready (sq_ready[STEPS]),
        .up_data  (sq_data[STEPS]),
        .dn_valid (lp_valid[0]),
        .dn_ready (lp_ready[0]),
        .dn_data  (lp_data[0])
    );

    // lapse division row
    for (genvar i = 0; i < STEPS; i++)
    begin : g_lapse
        gdm_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (lp_valid[i]),
            .up_ready (lp_ready[i]),
            .up_data  (lp_data[i]),
            .dn_valid (lp_valid[i+1]),
            .dn_ready (lp_ready[i+1]),
            .dn_data  (lp_data[i+1])
        );
    end

    gdm_ratio_setup u_ratio_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (lp_valid[STEPS]),
        .up_ready (lp_ready[STEPS]),
        .up_data  (lp_data[STEPS]),
        .dn_valid (rt_valid[0]),
        .dn_ready (rt_ready[0]),
        .dn_data  (rt_data[0])
    );

    // ratio division row
    for (genvar i = 0; i < STEPS; i++)
    begin : g_ratio
        gdm_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (rt_valid[i]),
            .up_ready (rt_ready[i]),
            .up_data  (rt_data[i]),
            .dn_valid (rt_valid[i+1]),
            .dn_ready (rt_ready[i+1]),
            .dn_data  (rt_data[i+1])
        );
    end

    gdm_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (rt_valid[STEPS]),
        .up_ready (rt_ready[STEPS]),
        .up_data  (rt_data[STEPS]),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .dn_data  (result_word)
    );

endmodule
